FILE: src/nfpa_pkg.sv
// Shared constants, types and codes of the next-fit page allocator.
package nfpa_pkg;

	localparam int NUM_PAGES  = 1024;
	localparam int PAGE_SHIFT = 12;

	// Page index, run-table entry (holds a count up to NUM_PAGES) and scan position widths.
	localparam int PAGE_W  = $clog2(NUM_PAGES);
	localparam int ENTRY_W = $clog2(NUM_PAGES + 1);
	localparam int POS_W   = ENTRY_W + 1;

	localparam int ADDR_W  = 32;
	localparam int BYTES_W = 23;
	localparam int REQ_PG_W = ADDR_W - PAGE_SHIFT + 1;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [ADDR_W-1:0] request_bytes;
		logic [ADDR_W-1:0] block_address;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic [ADDR_W-1:0]  result_address;
		logic [BYTES_W-1:0] block_bytes;
	} res_t;

endpackage

FILE: src/nfpa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module nfpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/nfpa_engine.sv
// Allocation scan, free lookup and run-table clearing sequencer.
module nfpa_engine
	import nfpa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  req_t               req,
	input  logic [ADDR_W-1:0]  heap_base,
	output logic               idle,
	output logic               res_valid,
	input  logic               res_take,
	output res_t               res,
	output logic               mem_we,
	output logic [PAGE_W-1:0]  mem_waddr,
	output logic [ENTRY_W-1:0] mem_wdata,
	output logic               mem_re,
	output logic [PAGE_W-1:0]  mem_raddr,
	input  logic [ENTRY_W-1:0] mem_rdata
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FREE,
		ST_RESULT
	} state_t;

	state_t state_q;
	logic [PAGE_W-1:0]  clr_q;
	logic [PAGE_W-1:0]  rover_q;
	res_t               res_q;

	// Working registers of the current item.
	logic [PAGE_W-1:0]  pos_q;
	logic [PAGE_W-1:0]  start_q;
	logic [ENTRY_W-1:0] run_q;
	logic [ENTRY_W-1:0] budget_q;
	logic [ENTRY_W-1:0] pages_q;
	logic [ADDR_W-1:0]  addr_q;

	// Decode of the incoming item.
	logic [REQ_PG_W-1:0] req_pages;
	logic                alloc_ok;
	logic [ADDR_W-1:0]   free_off;
	logic                free_ok;
	logic [PAGE_W-1:0]   free_page;

	// One scan step on the entry just read.
	logic                entry_free;
	logic [ENTRY_W-1:0]  run_n;
	logic [PAGE_W-1:0]   start_n;
	logic [ENTRY_W-1:0]  budget_n;
	logic [POS_W-1:0]    pos_sum;
	logic [PAGE_W-1:0]   pos_n;
	logic                found;
	logic                wrap;
	logic [POS_W-1:0]    block_end;
	logic [ENTRY_W+PAGE_SHIFT-1:0] alloc_bytes;
	logic [ENTRY_W+PAGE_SHIFT-1:0] free_bytes;

	always_comb begin
		req_pages = {1'b0, req.request_bytes[ADDR_W-1:PAGE_SHIFT]}
			+ REQ_PG_W'(|req.request_bytes[PAGE_SHIFT-1:0]);
		alloc_ok  = (req_pages != '0) && (req_pages <= REQ_PG_W'(NUM_PAGES));
		free_off  = req.block_address - heap_base;
		free_ok   = (free_off[PAGE_SHIFT-1:0] == '0)
			&& (free_off[ADDR_W-1:PAGE_SHIFT] < (ADDR_W-PAGE_SHIFT)'(NUM_PAGES));
		free_page = free_off[PAGE_SHIFT +: PAGE_W];
	end

	always_comb begin
		entry_free = (mem_rdata == '0);
		if (entry_free) begin
			run_n    = run_q + ENTRY_W'(1);
			start_n  = (run_q == '0) ? pos_q : start_q;
			budget_n = budget_q - ENTRY_W'(1);
			pos_sum  = POS_W'(pos_q) + POS_W'(1);
		end else begin
			run_n    = '0;
			start_n  = start_q;
			budget_n = (mem_rdata >= budget_q) ? '0 : budget_q - mem_rdata;
			pos_sum  = POS_W'(pos_q) + POS_W'(mem_rdata);
		end
		found     = (run_n >= pages_q);
		wrap      = (pos_sum >= POS_W'(NUM_PAGES));
		pos_n     = wrap ? '0 : pos_sum[PAGE_W-1:0];
		block_end = POS_W'(start_n) + POS_W'(pages_q);
		alloc_bytes = {pages_q, {PAGE_SHIFT{1'b0}}};
		free_bytes  = {mem_rdata, {PAGE_SHIFT{1'b0}}};
	end

	// Memory port control.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = pos_n;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				if (start) begin
					mem_re    = 1'b1;
					mem_raddr = (req.cmd == CMD_ALLOC) ? rover_q : free_page;
				end
			end
			ST_SCAN: begin
				if (found) begin
					mem_we    = 1'b1;
					mem_waddr = start_n;
					mem_wdata = pages_q;
				end else if (budget_n != '0) begin
					mem_re = 1'b1;
				end
			end
			ST_FREE: begin
				mem_we    = !entry_free;
				mem_waddr = pos_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			rover_q <= '0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + PAGE_W'(1);
					if (clr_q == PAGE_W'(NUM_PAGES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						res_q <= '0;
						if (req.cmd == CMD_ALLOC) begin
							state_q <= alloc_ok ? ST_SCAN : ST_RESULT;
						end else begin
							state_q <= free_ok ? ST_FREE : ST_RESULT;
						end
					end
				end
				ST_SCAN: begin
					if (found) begin
						rover_q <= (block_end >= POS_W'(NUM_PAGES)) ? '0 : start_n;
						res_q.ok             <= 1'b1;
						res_q.result_address <= heap_base
							+ (ADDR_W'(start_n) << PAGE_SHIFT);
						res_q.block_bytes    <= BYTES_W'(alloc_bytes);
						state_q <= ST_RESULT;
					end else if (budget_n == '0) begin
						state_q <= ST_RESULT;
					end
				end
				ST_FREE: begin
					if (!entry_free) begin
						res_q.ok             <= 1'b1;
						res_q.result_address <= addr_q;
						res_q.block_bytes    <= BYTES_W'(free_bytes);
					end
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Scan and free-lookup datapath registers; they carry no control meaning outside those items.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			pos_q    <= (req.cmd == CMD_ALLOC) ? rover_q : free_page;
			start_q  <= '0;
			run_q    <= '0;
			budget_q <= ENTRY_W'(NUM_PAGES);
			pages_q  <= req_pages[ENTRY_W-1:0];
			addr_q   <= req.block_address;
		end else if (state_q == ST_SCAN) begin
			pos_q    <= pos_n;
			start_q  <= start_n;
			run_q    <= wrap ? '0 : run_n;
			budget_q <= budget_n;
		end
	end

	assign idle      = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_RESULT);
	assign res       = res_q;

endmodule

FILE: src/next_fit_page_allocator.sv
// Top level of the next-fit page allocator: ports, heap base register and output register.
//
//  Channel  Signals                    Contents (lowest bit first)
//  -------  -------------------------  ------------------------------------------------
//  s_*      s_tvalid/s_tready          tuser: cmd; tdata: request_bytes, block_address
//  m_*      m_tvalid/m_tready          tuser: ok; tdata: result_address, block_bytes
//  cfg_*    cfg_we                     cfg_wdata: heap_base
//
// After reset the run table is swept to zero, one page per cycle;
// s_tready stays low during that pass.
// A free item passes through ST_FREE and then ST_RESULT on its way to the output
// register. An allocate item makes one run-table read per cycle in ST_SCAN (each scan
// step takes the next read address from the entry just read), up to 1024 steps, and
// then waits in ST_RESULT until its result moves into the output register. s_tready
// rises again as that happens; a rejected item goes straight to ST_RESULT.
// One item is worked on at a time; the next one is accepted once the previous result
// has moved into the output register; while m_tready stalls, the next result waits in ST_RESULT.
module next_fit_page_allocator
	import nfpa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] request_bytes, [63:32] block_address
	input  logic        s_tuser,   // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [31:0] result_address, [54:32] block_bytes, [55] zero
	output logic        m_tuser,   // [0] ok
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata  // heap_base
);

	logic [ADDR_W-1:0]  heap_base_q;
	logic               m_valid_q;
	res_t               m_res_q;

	req_t               req;
	logic               start;
	logic               eng_idle;
	logic               res_valid;
	logic               res_take;
	res_t               res;

	logic               mem_we;
	logic [PAGE_W-1:0]  mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic               mem_re;
	logic [PAGE_W-1:0]  mem_raddr;
	logic [ENTRY_W-1:0] mem_rdata;

	assign req.cmd           = s_tuser;
	assign req.request_bytes = s_tdata[31:0];
	assign req.block_address = s_tdata[63:32];

	assign s_tready = eng_idle;
	assign start    = s_tvalid && eng_idle;

	// The engine hands over its result whenever the output register is empty or draining.
	assign res_take = res_valid && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q <= 32'h8000_0000;
			m_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				heap_base_q <= cfg_wdata;
			end
			if (res_take) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_res_q.ok;
	assign m_tdata  = {1'b0, m_res_q.block_bytes, m_res_q.result_address};

	nfpa_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.heap_base (heap_base_q),
		.idle      (eng_idle),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Run table: page count of the block starting at each page, zero at every page that starts no block.
	nfpa_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_PAGES)
	) u_run_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
